// ===== design/move_command_line_parser_defines.svh =====
// ----------------------------------------------------------------------------
// move command line parser assertion macros
// concurrent check helpers used by the parser front end
// ----------------------------------------------------------------------------
`ifndef MOVE_COMMAND_LINE_PARSER_DEFINES_SVH
`define MOVE_COMMAND_LINE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define MCLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define MCLP_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define MCLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCLP_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/mclp_pkg.sv =====
// ----------------------------------------------------------------------------
// mclp_pkg
// types, character codes and helpers for the move command line parser
// ----------------------------------------------------------------------------
package mclp_pkg;

	typedef enum logic [3:0] {
		PH_P0     = 4'd0,
		PH_P1     = 4'd1,
		PH_P2     = 4'd2,
		PH_P3     = 4'd3,
		PH_P4     = 4'd4,
		PH_NOTCMD = 4'd5,
		PH_BAD    = 4'd6,
		PH_WS1    = 4'd7,
		PH_SGN1   = 4'd8,
		PH_DIG1   = 4'd9,
		PH_WS2    = 4'd10,
		PH_SGN2   = 4'd11,
		PH_DIG2   = 4'd12,
		PH_DONE   = 4'd13
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_CMD  = 2'd1,
		ST_BAD_ARGS = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	// one parsed line handed from front to back
	typedef struct packed {
		status_t            status;
		logic signed [15:0] turn_value;
		logic signed [15:0] move_value;
	} line_result_t;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CASE_OFS = 8'd32;

	localparam logic [15:0] MAG_LIMIT = 16'd32768;
	localparam logic [15:0] POS_MAX   = 16'd32767;

	localparam logic [23:0] MOVE_GAIN_RST = 24'd459;
	localparam logic [23:0] TURN_GAIN_RST = 24'd9830;

	localparam logic REG_MOVE_GAIN = 1'b0;
	localparam logic REG_TURN_GAIN = 1'b1;

	// lowercase letters of "move"
	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'd109;
			2'd1: ch = 8'd111;
			2'd2: ch = 8'd118;
			default: ch = 8'd101;
		endcase
		return ch;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) ||
			(c == 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// magnitude times ten plus digit, saturating at 32768
	function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
		logic [19:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, c[3:0]};
		return (v > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : v[15:0];
	endfunction

	function automatic logic signed [15:0] finish_number(input logic [15:0] acc,
			input logic neg);
		logic [15:0] r;
		if (neg) begin
			r = ~acc + 16'd1;
		end else if (acc > POS_MAX) begin
			r = POS_MAX;
		end else begin
			r = acc;
		end
		return signed'(r);
	endfunction

endpackage

// ===== design/mclp_front.sv =====
// ----------------------------------------------------------------------------
// mclp_front
// byte-serial parser: one byte a cycle while queue not full, result on newline
// ----------------------------------------------------------------------------
`include "move_command_line_parser_defines.svh"

module mclp_front #(
	parameter int MAX_LINE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  q_full,
	output logic                  push,
	output mclp_pkg::line_result_t entry
);
	import mclp_pkg::*;

	localparam int LEN_W = $clog2(MAX_LINE + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

	phase_t             phase_q, phase_n;
	logic [15:0]        acc_q, acc_n;
	logic               neg_q, neg_n;
	logic signed [15:0] first_q, first_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic               ended_q, ended_n;

	logic               accept;
	logic               start_num;
	logic               second;
	logic [7:0]         c;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign c        = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_P0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			first_q <= '0;
			len_q   <= '0;
			ended_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			first_q <= first_n;
			len_q   <= len_n;
			ended_q <= ended_n;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		first_n   = first_q;
		len_n     = len_q;
		ended_n   = ended_q;
		push      = 1'b0;
		start_num = 1'b0;
		second    = 1'b0;
		entry.status     = ST_OK;
		entry.turn_value = '0;
		entry.move_value = '0;

		if (accept && (c == CH_NL)) begin
			push = 1'b1;
			if (len_q >= LEN_MAX) begin
				entry.status = ST_TOO_LONG;
			end else if (phase_q <= PH_NOTCMD) begin
				entry.status = ST_NOT_CMD;
			end else if ((phase_q == PH_DIG2) || (phase_q == PH_DONE)) begin
				entry.turn_value = first_q;
				entry.move_value = finish_number(acc_q, neg_q);
			end else begin
				entry.status = ST_BAD_ARGS;
			end
			phase_n = PH_P0;
			acc_n   = '0;
			neg_n   = 1'b0;
			first_n = '0;
			len_n   = '0;
			ended_n = 1'b0;
		end else if (accept) begin
			if (len_q < LEN_MAX) begin
				len_n = len_q + LEN_W'(1);
			end
			if (c == CH_NUL) begin
				ended_n = 1'b1;
			end
			// nothing after a nul byte is parsed
			if (!ended_q && (c != CH_NUL)) begin
				case (phase_q)
					PH_P0, PH_P1, PH_P2, PH_P3: begin
						if (c == prefix_char(phase_q[1:0])) begin
							phase_n = phase_t'(phase_q + 4'd1);
						end else if (c == prefix_char(phase_q[1:0]) - CASE_OFS) begin
							// uppercase letter remembered for the literal check
							neg_n   = 1'b1;
							phase_n = phase_t'(phase_q + 4'd1);
						end else begin
							phase_n = PH_NOTCMD;
						end
					end
					PH_P4: begin
						if (c != CH_SPACE) begin
							phase_n = PH_NOTCMD;
						end else begin
							phase_n = neg_q ? PH_BAD : PH_WS1;
						end
						neg_n = 1'b0;
					end
					PH_WS1: begin
						start_num = 1'b1;
					end
					PH_SGN1, PH_SGN2: begin
						if (is_digit(c)) begin
							acc_n   = {12'b0, c[3:0]};
							phase_n = (phase_q == PH_SGN1) ? PH_DIG1 : PH_DIG2;
						end else begin
							phase_n = PH_BAD;
						end
					end
					PH_DIG1: begin
						if (is_digit(c)) begin
							acc_n = add_digit(acc_q, c);
						end else begin
							first_n   = finish_number(acc_q, neg_q);
							neg_n     = 1'b0;
							acc_n     = '0;
							phase_n   = PH_WS2;
							start_num = 1'b1;
							second    = 1'b1;
						end
					end
					PH_WS2: begin
						start_num = 1'b1;
						second    = 1'b1;
					end
					PH_DIG2: begin
						if (is_digit(c)) begin
							acc_n = add_digit(acc_q, c);
						end else begin
							phase_n = PH_DONE;
						end
					end
					default: begin
					end
				endcase

				// whitespace keeps the phase chosen by the case above
				if (start_num && !is_ws(c)) begin
					if ((c == CH_PLUS) || (c == CH_MINUS)) begin
						neg_n   = (c == CH_MINUS);
						phase_n = second ? PH_SGN2 : PH_SGN1;
					end else if (is_digit(c)) begin
						acc_n   = {12'b0, c[3:0]};
						phase_n = second ? PH_DIG2 : PH_DIG1;
					end else begin
						phase_n = PH_BAD;
					end
				end
			end
		end
	end

	`MCLP_ASSERT(a_line_restart, clk, arst_n, push |=> (phase_q == PH_P0) && (len_q == '0) && !ended_q, "parser state not cleared after newline")
	`MCLP_NEVER(a_len_bound, clk, arst_n, len_q > LEN_MAX, "line length counter past its limit")
	`MCLP_ASSERT(a_fail_zero, clk, arst_n, (push && (entry.status != ST_OK)) |-> (entry.turn_value == '0) && (entry.move_value == '0), "failed line carries nonzero values")

endmodule

// ===== design/mclp_queue.sv =====
// ----------------------------------------------------------------------------
// mclp_queue
// two-entry queue of line results between parser and scaler
// ----------------------------------------------------------------------------
module mclp_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mclp_pkg::line_result_t entry_in,
	input  logic                   pop,
	output logic                   full,
	output logic                   valid,
	output mclp_pkg::line_result_t entry_out
);
	import mclp_pkg::*;

	line_result_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = (count_q == 2'd2);
	assign valid     = (count_q != 2'd0);
	assign entry_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/mclp_back.sv =====
// ----------------------------------------------------------------------------
// mclp_back
// scales parsed values by the gains and holds the result for the output
// ----------------------------------------------------------------------------
module mclp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  mclp_pkg::line_result_t entry,
	output logic                   pop,
	input  logic signed [23:0]     move_gain,
	input  logic signed [23:0]     turn_gain,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [119:0]           m_tdata
);
	import mclp_pkg::*;

	logic               m_tvalid_q;
	status_t            status_q;
	logic signed [15:0] turn_value_q;
	logic signed [15:0] move_value_q;
	logic signed [39:0] move_speed_q;
	logic signed [39:0] turn_speed_q;

	logic signed [16:0] neg_move;
	logic signed [40:0] move_prod;
	logic signed [39:0] turn_prod;

	assign pop      = q_valid && (!m_tvalid_q || m_tready);
	assign neg_move = -17'(entry.move_value);
	assign move_prod = 41'(neg_move) * 41'(move_gain);
	assign turn_prod = 40'(entry.turn_value) * 40'(turn_gain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q     <= entry.status;
			turn_value_q <= entry.turn_value;
			move_value_q <= entry.move_value;
			move_speed_q <= move_prod[39:0];
			turn_speed_q <= turn_prod;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, turn_speed_q, move_speed_q, move_value_q, turn_value_q,
		status_q};

endmodule

// ===== design/move_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// move_command_line_parser
// streaming parser for "move <turn> <move>" text lines with gain scaling
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless the queue is full and keeps no line buffer.
// Each newline yields one result item carrying the status, the two
// saturated integers and the scaled speeds; other bytes yield nothing.
// The parser folds a byte into its state in the cycle it is accepted and
// pushes the line result into a two-entry queue; the scaler pops one entry
// a cycle while the output is free, through a 17x24 and a 16x24 multiplier
// into the output register, so results wait in the queue register first.
// s_tready drops only while the queue is full, which takes a stalled output.
// Gains sit at byte addresses 0 (move_gain) and 4 (turn_gain).
// ----------------------------------------------------------------------------
module move_command_line_parser #(
	parameter int MAX_LINE = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	// rx_byte[7:0]
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	// status[1:0], turn_value[17:2], move_value[33:18], move_speed[73:34],
	// turn_speed[113:74], zero fill[119:114]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [119:0]  m_tdata,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import mclp_pkg::*;

	logic [23:0]  move_gain_q;
	logic [23:0]  turn_gain_q;
	logic         cfg_wr;

	logic         q_full;
	logic         q_valid;
	logic         push;
	logic         pop;
	line_result_t push_entry;
	line_result_t head_entry;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_gain_q <= MOVE_GAIN_RST;
			turn_gain_q <= TURN_GAIN_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TURN_GAIN) begin
				turn_gain_q <= pwdata[23:0];
			end else begin
				move_gain_q <= pwdata[23:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_TURN_GAIN) ? {8'b0, turn_gain_q} : {8'b0, move_gain_q};

	mclp_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.entry    (push_entry)
	);

	mclp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (push_entry),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.entry_out (head_entry)
	);

	mclp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.entry     (head_entry),
		.pop       (pop),
		.move_gain (signed'(move_gain_q)),
		.turn_gain (signed'(turn_gain_q)),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
